@@ rtl/core/mm3_pkg.sv @@
// Shared types, constants and helper functions of the keyed MurmurHash3 block.
package mm3_pkg;

    localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2     = 32'h1b873593;
    localparam logic [31:0] MIX_ADD    = 32'he6546b64;
    localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RESET = 32'd4397;

    typedef struct packed {
        logic        do_block;
        logic        do_final;
        logic        fresh;
        logic [1:0]  tail_len;
        logic [31:0] word;
        logic [31:0] count;
        logic [31:0] key;
        logic [31:0] seed;
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_MIXB,
        ST_MIXT,
        ST_F1,
        ST_F2,
        ST_F3
    } t_back_state;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

endpackage

@@ rtl/core/mm3_front.sv @@
// Front end: gathers bytes into blocks and issues block and finish operations.
module mm3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_seed,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_has_byte,
    input  logic          i_last,
    input  logic [31:0]   i_dir_key,
    output logic          o_push,
    output mm3_pkg::t_op  o_op,
    input  logic          i_full
);
    import mm3_pkg::*;

    logic [31:0] r_part;
    logic [31:0] n_part;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [31:0] r_total;
    logic [31:0] n_total;
    logic        r_sent;
    logic        r_started;
    logic [31:0] r_str_seed;
    logic [31:0] str_seed;
    logic        acc;
    logic        blk_full;
    logic [31:0] part_with;

    assign o_ready   = !i_full;
    assign acc       = i_valid && !i_full;
    assign part_with = r_part | ({24'd0, i_data_byte} << {r_pos, 3'b000});
    assign blk_full  = i_has_byte && (r_pos == 2'd3);
    assign str_seed  = r_started ? r_str_seed : i_seed;

    always_comb begin
        n_part  = i_has_byte ? part_with : r_part;
        n_pos   = i_has_byte ? r_pos + 2'd1 : r_pos;
        n_total = i_has_byte ? r_total + 32'd1 : r_total;
    end

    assign o_push            = acc && (blk_full || i_last);
    assign o_op.do_block     = blk_full;
    assign o_op.do_final     = i_last;
    assign o_op.fresh        = !r_sent;
    assign o_op.tail_len     = n_pos;
    assign o_op.word         = n_part;
    assign o_op.count        = n_total;
    assign o_op.key          = i_dir_key;
    assign o_op.seed         = str_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part     <= '0;
            r_pos      <= '0;
            r_total    <= '0;
            r_sent     <= 1'b0;
            r_started  <= 1'b0;
            r_str_seed <= '0;
        end else if (acc) begin
            if (i_last) begin
                r_part    <= '0;
                r_pos     <= '0;
                r_total   <= '0;
                r_sent    <= 1'b0;
                r_started <= 1'b0;
            end else begin
                r_part  <= blk_full ? 32'd0 : n_part;
                r_pos   <= n_pos;
                r_total <= n_total;
                if (blk_full) begin
                    r_sent <= 1'b1;
                end
                if (i_has_byte && !r_started) begin
                    r_started  <= 1'b1;
                    r_str_seed <= i_seed;
                end
            end
        end
    end

endmodule

@@ rtl/core/mm3_queue.sv @@
// Two-entry operation queue between the front end and the hashing back end.
module mm3_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mm3_pkg::t_op  i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mm3_pkg::t_op  o_op
);
    import mm3_pkg::*;

    t_op        r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/mm3_back.sv @@
// Back end: block mixing, tail mixing, finaliser and the output register.
module mm3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mm3_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_hash
);
    import mm3_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_op         r_op;
    logic [31:0] r_h;
    logic [31:0] n_h;
    logic [31:0] r_k;
    logic [31:0] n_k;
    logic [31:0] r_out;
    logic        r_out_valid;
    logic        load_out;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic [31:0] hc;
    logic [31:0] hm;

    assign o_valid = r_out_valid;
    assign o_hash  = r_out;
    assign mul_p   = mul_a * mul_b;
    assign hc      = r_h ^ r_op.count;
    assign hm      = rotl13(r_h ^ r_k);

    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_k      = r_k;
        o_pop    = 1'b0;
        load_out = 1'b0;
        mul_a    = r_op.word;
        mul_b    = MIX_C1;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_h   = i_op.fresh ? i_op.seed : r_h;
                    if (i_op.do_block || (i_op.tail_len != 2'd0)) begin
                        n_state = ST_K1;
                    end else begin
                        n_state = ST_F1;
                    end
                end
            end
            ST_K1: begin
                n_k     = mul_p;
                n_state = ST_K2;
            end
            ST_K2: begin
                mul_a   = rotl15(r_k);
                mul_b   = MIX_C2;
                n_k     = mul_p;
                n_state = r_op.do_block ? ST_MIXB : ST_MIXT;
            end
            ST_MIXB: begin
                n_h     = (hm << 2) + hm + MIX_ADD;
                n_state = r_op.do_final ? ST_F1 : ST_IDLE;
            end
            ST_MIXT: begin
                n_h     = r_h ^ r_k;
                n_state = ST_F1;
            end
            ST_F1: begin
                mul_a   = hc ^ (hc >> 16);
                mul_b   = FIN_M1;
                n_h     = mul_p;
                n_state = ST_F2;
            end
            ST_F2: begin
                mul_a   = r_h ^ (r_h >> 13);
                mul_b   = FIN_M2;
                n_h     = mul_p;
                n_state = ST_F3;
            end
            ST_F3: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_k <= n_k;
        if (o_pop) begin
            r_op <= i_op;
        end
        if (load_out) begin
            r_out <= r_h ^ (r_h >> 16) ^ r_op.key;
        end
    end

endmodule

@@ rtl/core/murmur3_32_keyed_hash.sv @@
// Top level of the keyed MurmurHash3 x86 32-bit streaming hash.
//
// Input channel: one request per byte (i_data_byte, i_has_byte, i_last, i_dir_key),
// handshaken by i_valid and o_ready. An empty string is one request with
// i_has_byte low and i_last high. A request with neither byte nor last is dropped.
// Output channel: one hash per request with i_last high, on o_valid/i_ready.
// Configuration: i_cfg_valid with i_cfg_seed writes the seed; o_cfg_ready is
// always high. The front end samples the seed with a string's first byte, or with
// the lone request of an empty string, so a write mid-string applies to the next.
// The front end takes one byte per cycle while its two-entry queue has room.
// Each completed block takes the back end through dequeue, two multiplies and the
// fold, so long strings sustain one byte per cycle unless the receiver stalls.
// The hash of a string appears once the back end has dequeued its last operation,
// mixed any tail or final block still pending, run the finaliser steps F1 to F3
// and loaded the output register, later while earlier operations occupy it.
// A stalled receiver holds the result in the output register; the back end then
// waits, the queue fills and o_ready falls.
// Reset clears the queue, the output valid flag and the string state and loads
// seed 4397.
module murmur3_32_keyed_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    input  logic [31:0] i_dir_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_seed
);
    import mm3_pkg::*;

    logic [31:0] r_seed;
    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    t_op         op_in;
    t_op         op_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_seed;
        end
    end

    mm3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_seed),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .i_dir_key   (i_dir_key),
        .o_push      (push),
        .o_op        (op_in),
        .i_full      (full)
    );

    mm3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (op_out)
    );

    mm3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (op_out),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_hash    (o_hash)
    );

endmodule

@@ rtl/core/mm3_checker.sv @@
// Port-level checker of the keyed MurmurHash3 block and its bind statement.
module mm3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_hash
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hash))
        else $error("Stalled result changed or vanished.");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("Input not ready right after reset.");

    a_hash_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_hash))
        else $error("Result carries unknown bits.");

endmodule

bind murmur3_32_keyed_hash mm3_checker u_mm3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_hash  (o_hash)
);

@@ test/murmur3_32_keyed_hash_tb.sv @@
// Self-checking testbench for the keyed MurmurHash3 x86 32-bit streaming hash.
module murmur3_32_keyed_hash_tb;
    import mm3_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int N_DIR = 28;
    localparam int N_PHASES = 6;
    localparam int PHASE_ITEMS = 150;

    typedef enum logic {
        ROW_REQ,
        ROW_SEED
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        last;
        logic [31:0] word;
        logic        fixed;
        logic [31:0] fixed_hash;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_last = 1'b0;
    logic [31:0] i_dir_key = 32'h0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_hash;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_seed = 32'h0;

    logic [31:0] seed_reg;
    logic [31:0] str_hash;
    logic [31:0] str_block;
    logic [1:0]  str_pos;
    logic [31:0] str_count;
    logic        str_open;

    logic [31:0] pending_hashes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 4;
    int          strings_sent = 0;
    int          bytes_sent = 0;
    int          ignored_sent = 0;
    int          seeds_written = 0;
    int          hashes_checked = 0;
    int          phase_items = 0;

    t_stim_row   dir_tab [N_DIR];

    murmur3_32_keyed_hash uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .i_dir_key   (i_dir_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hash      (o_hash),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = {t[16:0], t[31:17]};
        scramble_word = t * MIX_C2;
    endfunction

    task automatic clear_string();
        str_hash = seed_reg;
        str_block = 32'h0;
        str_pos = 2'd0;
        str_count = 32'h0;
        str_open = 1'b0;
    endtask

    task automatic hash_request(input logic [7:0] b, input logic hb, input logic lst,
                                input logic [31:0] key, output logic gives,
                                output logic [31:0] h);
        gives = 1'b0;
        h = 32'h0;
        if (hb) begin
            if (!str_open) begin
                str_hash = seed_reg;
                str_open = 1'b1;
            end
            str_block = str_block | ({24'h0, b} << {str_pos, 3'b000});
            str_pos = str_pos + 2'd1;
            str_count = str_count + 32'd1;
            if (str_pos == 2'd0) begin
                str_hash = str_hash ^ scramble_word(str_block);
                str_hash = {str_hash[18:0], str_hash[31:19]};
                str_hash = str_hash * 32'd5 + MIX_ADD;
                str_block = 32'h0;
            end
        end
        if (lst) begin
            h = str_open ? str_hash : seed_reg;
            if (str_pos != 2'd0) begin
                h = h ^ scramble_word(str_block);
            end
            h = h ^ str_count;
            h = h ^ (h >> 16);
            h = h * FIN_M1;
            h = h ^ (h >> 13);
            h = h * FIN_M2;
            h = h ^ (h >> 16);
            h = h ^ key;
            gives = 1'b1;
            clear_string();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s, got %08h, expected %08h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch("hash with none pending", o_hash, 32'h0);
            end else begin
                if (o_hash !== pending_hashes[0]) begin
                    report_mismatch("hash", o_hash, pending_hashes[0]);
                end
                void'(pending_hashes.pop_front());
                hashes_checked++;
            end
        end
    end

    int       stall_mode = 0;
    int       stall_run = 0;
    logic     ready_level = 1'b1;

    always @(posedge i_clk) begin
        if (cycle_count % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_run == 0) begin
                    ready_level = ~ready_level;
                    stall_run = $urandom_range(1, 20);
                end
                stall_run--;
                i_ready <= ready_level;
            end
        endcase
    end

    task automatic send_req(input logic [7:0] b, input logic hb, input logic lst,
                            input logic [31:0] key, input logic use_fixed,
                            input logic [31:0] fixed_hash);
        logic        took;
        logic        gives;
        logic [31:0] h;
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_has_byte <= hb;
        i_last <= lst;
        i_dir_key <= key;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end
        hash_request(b, hb, lst, key, gives, h);
        if (gives) begin
            pending_hashes.push_back(use_fixed ? fixed_hash : h);
            strings_sent++;
        end
        if (hb) begin
            bytes_sent++;
        end
        if (hb || lst) begin
            phase_items++;
        end else begin
            ignored_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        logic took;
        i_cfg_valid <= 1'b1;
        i_cfg_seed <= v;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        seed_reg = v;
        seeds_written++;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: pick_key = 32'h0;
            1: pick_key = 32'hffffffff;
            default: pick_key = $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0: pick_byte = 8'h00;
            1: pick_byte = 8'hff;
            default: pick_byte = 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_string();
        int n;
        int r;
        logic split_end;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            n = 0;
        end else if (r < 88) begin
            n = $urandom_range(1, 12);
        end else begin
            n = $urandom_range(13, 48);
        end
        split_end = (n == 0) || ($urandom_range(0, 4) == 0);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_req(pick_byte(), 1'b0, 1'b0, pick_key(), 1'b0, 32'h0);
            end
            send_req(pick_byte(), 1'b1, (k == n - 1) && !split_end, pick_key(),
                     1'b0, 32'h0);
        end
        if (split_end) begin
            send_req(pick_byte(), 1'b0, 1'b1, pick_key(), 1'b0, 32'h0);
        end
    endtask

    initial begin
        logic [31:0] phase_seed;
        dir_tab = '{
            '{ROW_REQ,  8'h00, 1'b0, 1'b1, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b0, 1'b0, 32'hffffffff, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b1, 1'b1, 32'hffffffff, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h80, 1'b1, 1'b1, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h01, 1'b1, 1'b0, 32'h12345678, 1'b0, 32'h0},
            '{ROW_REQ,  8'h02, 1'b1, 1'b0, 32'h12345678, 1'b0, 32'h0},
            '{ROW_REQ,  8'h03, 1'b1, 1'b1, 32'h12345678, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b1, 1'b1, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h11, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'hff, 1'b0, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h22, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h33, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h44, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b0, 1'b1, 32'hffffffff, 1'b0, 32'h0},
            '{ROW_SEED, 8'h00, 1'b0, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b0, 1'b1, 32'h00000000, 1'b1, 32'h00000000},
            '{ROW_REQ,  8'h00, 1'b0, 1'b1, 32'hffffffff, 1'b1, 32'hffffffff},
            '{ROW_SEED, 8'h00, 1'b0, 1'b0, 32'hffffffff, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b0, 1'b1, 32'ha5a5a5a5, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
            '{ROW_REQ,  8'h00, 1'b1, 1'b1, 32'h5a5a5a5a, 1'b0, 32'h0}
        };
        seed_reg = SEED_RESET;
        clear_string();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].kind == ROW_SEED) begin
                settle();
                write_seed(dir_tab[i].word);
            end else begin
                send_req(dir_tab[i].data_byte, dir_tab[i].has_byte, dir_tab[i].last,
                         dir_tab[i].word, dir_tab[i].fixed, dir_tab[i].fixed_hash);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                1: phase_seed = 32'h00000000;
                3: phase_seed = 32'hffffffff;
                5: phase_seed = 32'h80000000;
                default: phase_seed = $urandom;
            endcase
            write_seed(phase_seed);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 29) == 0) begin
                    settle();
                end
                send_string();
            end
        end

        settle();
        if (pending_hashes.size() != 0) begin
            report_mismatch("hashes still pending at the end", pending_hashes.size(), 0);
        end
        $display("Covered %0d strings, %0d bytes and %0d ignored requests,",
                 strings_sent, bytes_sent, ignored_sent);
        $display("with %0d seed writes and %0d hashes checked.",
                 seeds_written, hashes_checked);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
